>>> rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// shared types for the box transform unit: coordinate width and the packed
// input and result items
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int XFORM_WIDTH = 64;
    localparam int INDEX_WIDTH = 3;

    localparam logic [INDEX_WIDTH-1:0] XFORM_ROW0_LO = 3'd0;
    localparam logic [INDEX_WIDTH-1:0] XFORM_ROW0_HI = 3'd1;
    localparam logic [INDEX_WIDTH-1:0] XFORM_ROW1_LO = 3'd2;
    localparam logic [INDEX_WIDTH-1:0] XFORM_ROW1_HI = 3'd3;
    localparam logic [INDEX_WIDTH-1:0] XFORM_ROW2_LO = 3'd4;
    localparam logic [INDEX_WIDTH-1:0] XFORM_ROW2_HI = 3'd5;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] lower_x;
        logic signed [COORD_WIDTH-1:0] lower_y;
        logic signed [COORD_WIDTH-1:0] lower_z;
        logic signed [COORD_WIDTH-1:0] upper_x;
        logic signed [COORD_WIDTH-1:0] upper_y;
        logic signed [COORD_WIDTH-1:0] upper_z;
    } box_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_max_x;
        logic signed [COORD_WIDTH-1:0] out_max_y;
        logic signed [COORD_WIDTH-1:0] out_max_z;
        logic signed [COORD_WIDTH-1:0] out_min_x;
        logic signed [COORD_WIDTH-1:0] out_min_y;
        logic signed [COORD_WIDTH-1:0] out_min_z;
    } bound_item_t;

endpackage

>>> rtl/aabb_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit
// transforms an axis-aligned box by a 3x4 Q16.16 affine matrix and returns
// the bounding box of the eight transformed corners
// ----------------------------------------------------------------------------
// usage:
//   input channel: drive box and pulse start; the item is taken at any edge
//   with start high and busy low. busy stays low, so one box per cycle.
//   result channel: done is high for one cycle with result valid in that
//   cycle. the receiver cannot hold results off and none is needed.
//   the pipeline has one register per step, in order: multiply, max/min
//   select, pair sums, final sum, shift and saturate. throughput: 1 item
//   per cycle, set by the fully pipelined multipliers of the three row units.
//   matrix: six 64-bit registers written through wr_en / wr_index / wr_data,
//   only while no item is in flight (the user's rule, not enforced); indexes
//   above five are ignored. reset: clears the pipeline valid bits and loads
//   the identity matrix with no translation; items in flight are dropped.
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  aat_pkg::box_item_t                   box,
    output logic                                 done,
    output aat_pkg::bound_item_t                 result,
    input  logic                                 wr_en,
    input  logic [aat_pkg::INDEX_WIDTH-1:0]      wr_index,
    input  logic [aat_pkg::XFORM_WIDTH-1:0]      wr_data
);

    localparam int LATENCY = 5;

    localparam logic [aat_pkg::XFORM_WIDTH-1:0] ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [aat_pkg::XFORM_WIDTH-1:0] ONE_HI = 64'h0001_0000_0000_0000;

    logic [aat_pkg::XFORM_WIDTH-1:0] xform_reg [6];
    logic [LATENCY-1:0]              valid_reg;
    logic                            accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xform_reg[0] <= ONE_LO;
            xform_reg[1] <= '0;
            xform_reg[2] <= ONE_HI;
            xform_reg[3] <= '0;
            xform_reg[4] <= '0;
            xform_reg[5] <= ONE_LO;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                aat_pkg::XFORM_ROW0_LO: xform_reg[0] <= wr_data;
                aat_pkg::XFORM_ROW0_HI: xform_reg[1] <= wr_data;
                aat_pkg::XFORM_ROW1_LO: xform_reg[2] <= wr_data;
                aat_pkg::XFORM_ROW1_HI: xform_reg[3] <= wr_data;
                aat_pkg::XFORM_ROW2_LO: xform_reg[4] <= wr_data;
                aat_pkg::XFORM_ROW2_HI: xform_reg[5] <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    assign done = valid_reg[LATENCY-1];

    aat_row u_row_x (
        .clk     (clk),
        .box     (box),
        .row_lo  (xform_reg[0]),
        .row_hi  (xform_reg[1]),
        .max_val (result.out_max_x),
        .min_val (result.out_min_x)
    );

    aat_row u_row_y (
        .clk     (clk),
        .box     (box),
        .row_lo  (xform_reg[2]),
        .row_hi  (xform_reg[3]),
        .max_val (result.out_max_y),
        .min_val (result.out_min_y)
    );

    aat_row u_row_z (
        .clk     (clk),
        .box     (box),
        .row_lo  (xform_reg[4]),
        .row_hi  (xform_reg[5]),
        .max_val (result.out_max_z),
        .min_val (result.out_min_z)
    );

    a_accept_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted item did not come out after the pipeline latency");

    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##5 !done)
        else $error("result strobe without an accepted item");

    a_bound_order : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_max_x >= result.out_min_x) &&
                 (result.out_max_y >= result.out_min_y) &&
                 (result.out_max_z >= result.out_min_z))
        else $error("result max below min");

endmodule

>>> rtl/aat_row.sv
// ----------------------------------------------------------------------------
// aat_row
// one output axis: per-term products, max/min select, two-level sum, then
// floor shift by 16 and saturation, five register stages
// ----------------------------------------------------------------------------
module aat_row (
    input  logic                                     clk,
    input  aat_pkg::box_item_t                       box,
    input  logic [aat_pkg::XFORM_WIDTH-1:0]          row_lo,
    input  logic [aat_pkg::XFORM_WIDTH-1:0]          row_hi,
    output logic signed [aat_pkg::COORD_WIDTH-1:0]   max_val,
    output logic signed [aat_pkg::COORD_WIDTH-1:0]   min_val
);

    localparam int CW = aat_pkg::COORD_WIDTH;
    localparam int PW = 32 + CW;
    localparam int SW = PW + 2;
    localparam int HW = SW - 16;

    logic signed [CW-1:0] lo_c [3];
    logic signed [CW-1:0] hi_c [3];
    logic signed [31:0]   m    [3];
    logic signed [31:0]   t;

    logic signed [PW-1:0] p_next   [3];
    logic signed [PW-1:0] q_next   [3];
    logic signed [PW-1:0] p_reg    [3];
    logic signed [PW-1:0] q_reg    [3];
    logic signed [PW-1:0] big_reg  [3];
    logic signed [PW-1:0] sml_reg  [3];
    logic signed [31:0]   t1_reg;
    logic signed [31:0]   t2_reg;
    logic signed [SW-1:0] t_ext;
    logic signed [SW-1:0] big_a_reg;
    logic signed [SW-1:0] big_b_reg;
    logic signed [SW-1:0] sml_a_reg;
    logic signed [SW-1:0] sml_b_reg;
    logic signed [SW-1:0] big_sum_reg;
    logic signed [SW-1:0] sml_sum_reg;
    logic signed [CW-1:0] max_reg;
    logic signed [CW-1:0] min_reg;

    function automatic logic signed [CW-1:0] shift_sat(input logic signed [SW-1:0] v);
        logic signed [HW-1:0] sh;
        logic signed [CW-1:0] r;
        sh = HW'(v >>> 16);
        if (sh[HW-1:CW-1] == '0 || sh[HW-1:CW-1] == '1) begin
            r = sh[CW-1:0];
        end else if (sh[HW-1]) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    assign lo_c[0] = box.lower_x;
    assign lo_c[1] = box.lower_y;
    assign lo_c[2] = box.lower_z;
    assign hi_c[0] = box.upper_x;
    assign hi_c[1] = box.upper_y;
    assign hi_c[2] = box.upper_z;
    assign m[0]    = row_lo[31:0];
    assign m[1]    = row_lo[63:32];
    assign m[2]    = row_hi[31:0];
    assign t       = row_hi[63:32];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            p_next[c] = m[c] * lo_c[c];
            q_next[c] = m[c] * hi_c[c];
        end
    end

    assign t_ext = SW'(signed'({t2_reg, 16'h0000}));

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            p_reg[c] <= p_next[c];
            q_reg[c] <= q_next[c];
            if (p_reg[c] < q_reg[c])
            begin
                big_reg[c] <= q_reg[c];
                sml_reg[c] <= p_reg[c];
            end
            else
            begin
                big_reg[c] <= p_reg[c];
                sml_reg[c] <= q_reg[c];
            end
        end
        t1_reg      <= t;
        t2_reg      <= t1_reg;
        big_a_reg   <= t_ext + SW'(big_reg[0]);
        big_b_reg   <= SW'(big_reg[1]) + SW'(big_reg[2]);
        sml_a_reg   <= t_ext + SW'(sml_reg[0]);
        sml_b_reg   <= SW'(sml_reg[1]) + SW'(sml_reg[2]);
        big_sum_reg <= big_a_reg + big_b_reg;
        sml_sum_reg <= sml_a_reg + sml_b_reg;
        max_reg     <= shift_sat(big_sum_reg);
        min_reg     <= shift_sat(sml_sum_reg);
    end

    assign max_val = max_reg;
    assign min_val = min_reg;

endmodule
